// ===== sv/rdns_pkg.sv =====
// shared types and constants for the range-doppler noise statistics block
package rdns_pkg;

    localparam int SAMPLE_W = 24;
    localparam int SUM_W    = 36;
    localparam int POWER_W  = 60;
    localparam int COUNT_W  = 12;
    localparam int VAR_W    = 48;
    localparam int SD_W     = 24;
    localparam int MEAN_W   = 32;
    localparam int DIV_W    = 60;
    localparam int MEM_W    = 2 * SUM_W + POWER_W;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ACCUM  = 2'd1,
        CMD_END    = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_RANGE     = 3'd1,
        STS_NO_REC    = 3'd2,
        STS_LOW_VAR   = 3'd3,
        STS_SATURATED = 3'd4
    } status_code_t;

    typedef enum logic [1:0] {
        DIV_SEL_RE  = 2'd0,
        DIV_SEL_IM  = 2'd1,
        DIV_SEL_PW  = 2'd2
    } div_sel_t;

    typedef enum logic [1:0] {
        CFG_DELAYS = 2'd0,
        CFG_FFT    = 2'd1,
        CFG_LIMIT  = 2'd2
    } cfg_index_t;

    // controller to datapath
    typedef struct packed {
        logic     latch_in;
        logic     addr_calc;
        logic     cnt_clear;
        logic     cnt_inc;
        logic     clr_step;
        logic     mem_rd;
        logic     acc_wr;
        logic     div_start;
        div_sel_t div_sel;
        logic     mean_sq;
        logic     var_calc;
        logic     sqrt_start;
        logic     res_load;
    } dp_ctrl_t;

    // datapath to controller
    typedef struct packed {
        cmd_code_t cmd;
        logic      in_range;
        logic      rec_zero;
        logic      clr_last;
        logic      div_done;
        logic      sqrt_done;
        logic      out_busy;
    } dp_stat_t;

endpackage

// ===== sv/rdns_div.sv =====
// restoring divider, one quotient bit per cycle
module rdns_div
    import rdns_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DIV_W-1:0]    dividend,
    input  logic [COUNT_W-1:0]  divisor,
    output logic                busy,
    output logic                done,
    output logic [DIV_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(DIV_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0]    num_reg, num_next;
    logic [COUNT_W-1:0]  den_reg, den_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [COUNT_W:0]    rem_sh;
    logic                q_bit;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        rem_sh    = {rem_reg, num_reg[DIV_W-1]};
        q_bit     = rem_sh >= {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = q_bit ? COUNT_W'(rem_sh - {1'b0, den_reg}) : COUNT_W'(rem_sh);
            num_next = {num_reg[DIV_W-2:0], q_bit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ===== sv/rdns_isqrt.sv =====
// integer square root, one result bit per cycle
module rdns_isqrt
    import rdns_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [VAR_W-1:0]  value,
    output logic              done,
    output logic [SD_W-1:0]   root
);

    localparam int CNT_W = $clog2(SD_W);
    localparam int REM_W = SD_W + 2;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VAR_W-1:0]   val_reg, val_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [SD_W-1:0]    root_reg, root_next;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        rem_sh    = {rem_reg, val_reg[VAR_W-1:VAR_W-2]};
        trial     = {2'b00, root_reg, 2'b01};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            val_next  = value;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            val_next = {val_reg[VAR_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[SD_W-2:0], 1'b1};
            end else begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[SD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(SD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== sv/rdns_datapath.sv =====
// cell memory, config registers, accumulate and query arithmetic, result register
module rdns_datapath
    import rdns_pkg::*;
#(
    parameter int MAX_DELAYS  = 64,
    parameter int MAX_DOPPLER = 256,
    parameter int MAX_RECORDS = 4095
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  dp_ctrl_t        ctl,
    output dp_stat_t        stat,
    input  logic [1:0]      s_tuser,
    input  logic [63:0]     s_tdata,
    input  logic            cfg_valid,
    input  logic [1:0]      cfg_index,
    input  logic [47:0]     cfg_data,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [151:0]    m_tdata,
    output logic [2:0]      m_tuser
);

    localparam int CELLS = MAX_DELAYS * MAX_DOPPLER;
    localparam int AW    = $clog2(CELLS);

    // config
    logic [6:0]        delays_reg;
    logic [8:0]        fft_reg;
    logic [VAR_W-1:0]  limit_reg;

    // latched request
    cmd_code_t              cmd_reg;
    logic [5:0]             dly_reg;
    logic [7:0]             dop_reg;
    logic signed [SAMPLE_W-1:0] re_reg;
    logic signed [SAMPLE_W-1:0] im_reg;

    logic [AW-1:0]          addr_reg;
    logic                   in_range_reg;
    logic [AW-1:0]          clr_addr_reg;
    logic [COUNT_W-1:0]     count_reg;
    logic                   sat_reg;

    logic [MEM_W-1:0]       mem [CELLS];
    logic [MEM_W-1:0]       rd_reg;

    logic [63:0]            prod_a_reg;
    logic [63:0]            prod_b_reg;
    logic signed [MEAN_W-1:0] mean_re_reg, mean_im_reg;
    logic [MEAN_W-1:0]      mag_re_reg, mag_im_reg;
    logic [POWER_W-1:0]     pm_reg;
    logic [VAR_W-1:0]       var_reg;
    logic                   low_reg;
    div_sel_t               div_sel_reg;

    logic                   m_tvalid_reg;
    logic [2:0]             status_out_reg;
    logic [MEAN_W-1:0]      mre_out_reg, mim_out_reg;
    logic [VAR_W-1:0]       var_out_reg;
    logic [SD_W-1:0]        sd_out_reg;
    logic [COUNT_W-1:0]     rec_out_reg;

    // address and range
    logic [6:0]   nd;
    logic [8:0]   nf;
    logic         in_range_c;
    logic [15:0]  addr_full;

    always_comb begin
        nd = (13'(delays_reg) < 13'(MAX_DELAYS)) ? delays_reg : 7'(MAX_DELAYS);
        nf = (13'(fft_reg) < 13'(MAX_DOPPLER)) ? fft_reg : 9'(MAX_DOPPLER);
        in_range_c = (7'(dly_reg) < nd) && (9'(dop_reg) < nf);
        addr_full  = 16'(dop_reg * nd) + 16'(dly_reg);
    end

    // memory word fields
    logic [SUM_W-1:0]   rd_re, rd_im;
    logic [POWER_W-1:0] rd_pw;
    logic [MEM_W-1:0]   acc_word;

    assign rd_re = rd_reg[SUM_W-1:0];
    assign rd_im = rd_reg[2*SUM_W-1:SUM_W];
    assign rd_pw = rd_reg[MEM_W-1:2*SUM_W];
    assign acc_word = {
        rd_pw + POWER_W'(prod_a_reg) + POWER_W'(prod_b_reg),
        rd_im + SUM_W'(im_reg),
        rd_re + SUM_W'(re_reg)
    };

    always_ff @(posedge aclk) begin
        if (ctl.clr_step) begin
            mem[clr_addr_reg] <= '0;
        end else if (ctl.acc_wr) begin
            mem[addr_reg] <= acc_word;
        end
        if (ctl.mem_rd) begin
            rd_reg <= mem[addr_reg];
        end
    end

    // divider operand select
    logic [SUM_W-1:0]  sum_sel;
    logic              sum_neg;
    logic [SUM_W-1:0]  sum_mag;
    logic [DIV_W-1:0]  dividend;
    logic              div_busy, div_done;
    logic [DIV_W-1:0]  quotient;

    always_comb begin
        sum_sel  = (ctl.div_sel == DIV_SEL_IM) ? rd_im : rd_re;
        sum_neg  = sum_sel[SUM_W-1];
        sum_mag  = sum_neg ? (~sum_sel + 1'b1) : sum_sel;
        dividend = (ctl.div_sel == DIV_SEL_PW) ? DIV_W'(rd_pw) : DIV_W'({sum_mag, 8'h00});
    end

    rdns_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (ctl.div_start),
        .dividend (dividend),
        .divisor  (count_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    // mean with saturation, from quotient magnitude and sign
    logic                   q_neg;
    logic [MEAN_W-1:0]      q_mag;
    logic signed [MEAN_W-1:0] q_mean;

    always_comb begin
        q_neg = (div_sel_reg == DIV_SEL_IM) ? rd_im[SUM_W-1] : rd_re[SUM_W-1];
        if (!q_neg) begin
            q_mag = (quotient > DIV_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : MEAN_W'(quotient);
        end else begin
            q_mag = (quotient > DIV_W'(32'h8000_0000)) ? 32'h8000_0000 : MEAN_W'(quotient);
        end
        q_mean = q_neg ? -$signed(q_mag) : $signed(q_mag);
    end

    // variance
    logic [64:0]        sq_sum;
    logic [VAR_W:0]     sq_shift;
    logic [POWER_W:0]   diff;
    logic [VAR_W-1:0]   var_c;

    always_comb begin
        sq_sum   = 65'(prod_a_reg) + 65'(prod_b_reg);
        sq_shift = (VAR_W + 1)'(sq_sum >> 16);
        diff     = (POWER_W + 1)'(pm_reg) - (POWER_W + 1)'(sq_shift);
        if (POWER_W'(sq_shift) >= pm_reg) begin
            var_c = '0;
        end else if (diff[POWER_W:VAR_W] != '0) begin
            var_c = '1;
        end else begin
            var_c = diff[VAR_W-1:0];
        end
    end

    logic              sqrt_done;
    logic [SD_W-1:0]   sqrt_root;

    rdns_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctl.sqrt_start),
        .value   (var_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    logic res_ok;
    assign res_ok = (cmd_reg == CMD_QUERY) && in_range_reg && (count_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delays_reg   <= 7'd64;
            fft_reg      <= 9'd256;
            limit_reg    <= 48'd1;
            count_reg    <= '0;
            sat_reg      <= 1'b0;
            clr_addr_reg <= '0;
            m_tvalid_reg <= 1'b0;
            cmd_reg      <= CMD_CLEAR;
            in_range_reg <= 1'b0;
            div_sel_reg  <= DIV_SEL_RE;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_DELAYS: delays_reg <= cfg_data[6:0];
                    CFG_FFT:    fft_reg    <= cfg_data[8:0];
                    CFG_LIMIT:  limit_reg  <= cfg_data[VAR_W-1:0];
                    default: ;
                endcase
            end
            if (ctl.latch_in) begin
                cmd_reg <= cmd_code_t'(s_tuser);
            end
            if (ctl.addr_calc) begin
                in_range_reg <= in_range_c;
            end
            if (ctl.cnt_clear) begin
                count_reg <= '0;
                sat_reg   <= 1'b0;
            end else if (ctl.cnt_inc) begin
                if (count_reg >= COUNT_W'(MAX_RECORDS)) begin
                    count_reg <= COUNT_W'(MAX_RECORDS);
                    sat_reg   <= 1'b1;
                end else begin
                    count_reg <= count_reg + 1'b1;
                    sat_reg   <= 1'b0;
                end
            end
            if (ctl.clr_step) begin
                clr_addr_reg <= (clr_addr_reg == AW'(CELLS - 1)) ? '0 : clr_addr_reg + 1'b1;
            end
            if (ctl.div_start) begin
                div_sel_reg <= ctl.div_sel;
            end
            if (ctl.res_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.latch_in) begin
            dly_reg <= s_tdata[5:0];
            dop_reg <= s_tdata[13:6];
            re_reg  <= s_tdata[37:14];
            im_reg  <= s_tdata[61:38];
        end
        if (ctl.addr_calc) begin
            addr_reg   <= in_range_c ? AW'(addr_full) : '0;
            prod_a_reg <= 64'(48'(re_reg * re_reg));
            prod_b_reg <= 64'(48'(im_reg * im_reg));
        end else if (ctl.mean_sq) begin
            prod_a_reg <= mag_re_reg * mag_re_reg;
            prod_b_reg <= mag_im_reg * mag_im_reg;
        end
        if (div_done) begin
            unique case (div_sel_reg)
                DIV_SEL_RE: begin
                    mean_re_reg <= q_mean;
                    mag_re_reg  <= q_mag;
                end
                DIV_SEL_IM: begin
                    mean_im_reg <= q_mean;
                    mag_im_reg  <= q_mag;
                end
                default: pm_reg <= POWER_W'(quotient);
            endcase
        end
        if (ctl.var_calc) begin
            var_reg <= var_c;
            low_reg <= var_c < limit_reg;
        end
        if (ctl.res_load) begin
            unique case (cmd_reg)
                CMD_CLEAR: status_out_reg <= STS_OK;
                CMD_ACCUM: status_out_reg <= in_range_reg ? STS_OK : STS_RANGE;
                CMD_END:   status_out_reg <= sat_reg ? STS_SATURATED : STS_OK;
                default: begin
                    if (!in_range_reg)          status_out_reg <= STS_RANGE;
                    else if (count_reg == '0)   status_out_reg <= STS_NO_REC;
                    else if (low_reg)           status_out_reg <= STS_LOW_VAR;
                    else                        status_out_reg <= STS_OK;
                end
            endcase
            mre_out_reg <= res_ok ? mean_re_reg : '0;
            mim_out_reg <= res_ok ? mean_im_reg : '0;
            var_out_reg <= res_ok ? var_reg : '0;
            sd_out_reg  <= res_ok ? sqrt_root : '0;
            rec_out_reg <= count_reg;
        end
    end

    always_comb begin
        stat.cmd       = cmd_reg;
        stat.in_range  = in_range_reg;
        stat.rec_zero  = count_reg == '0;
        stat.clr_last  = clr_addr_reg == AW'(CELLS - 1);
        stat.div_done  = div_done;
        stat.sqrt_done = sqrt_done;
        stat.out_busy  = m_tvalid_reg && !m_tready;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_out_reg;
    assign m_tdata  = {4'h0, rec_out_reg, sd_out_reg, var_out_reg, mim_out_reg, mre_out_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_RECORDS))
        else $error("record count above maximum");

    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.clr_step && ctl.acc_wr))
        else $error("clear sweep and accumulate write together");

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.res_load |-> !(m_tvalid_reg && !m_tready))
        else $error("result loaded over a pending result");

endmodule

// ===== sv/rdns_ctrl.sv =====
// request sequencer for the noise statistics datapath
module rdns_ctrl
    import rdns_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_stat_t  stat,
    output dp_ctrl_t  ctl
);

    typedef enum logic [3:0] {
        ST_CLR_INIT,
        ST_IDLE,
        ST_ADDR,
        ST_RD,
        ST_DATA,
        ST_DIV_RE,
        ST_DIV_IM,
        ST_DIV_PW,
        ST_MSQ,
        ST_VAR,
        ST_SQS,
        ST_SQRT,
        ST_CLR_CMD,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.div_sel = DIV_SEL_RE;
        s_tready   = state_reg == ST_IDLE;
        unique case (state_reg)
            ST_CLR_INIT: begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctl.latch_in = 1'b1;
                    state_next   = ST_ADDR;
                end
            end
            ST_ADDR: begin
                ctl.addr_calc = 1'b1;
                unique case (stat.cmd)
                    CMD_CLEAR: begin
                        ctl.cnt_clear = 1'b1;
                        state_next    = ST_CLR_CMD;
                    end
                    CMD_END: begin
                        ctl.cnt_inc = 1'b1;
                        state_next  = ST_FIN;
                    end
                    default: state_next = ST_RD;
                endcase
            end
            ST_RD: begin
                ctl.mem_rd = 1'b1;
                state_next = ST_DATA;
            end
            ST_DATA: begin
                if (stat.cmd == CMD_ACCUM) begin
                    ctl.acc_wr = stat.in_range;
                    state_next = ST_FIN;
                end else if (!stat.in_range || stat.rec_zero) begin
                    state_next = ST_FIN;
                end else begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = DIV_SEL_RE;
                    state_next    = ST_DIV_RE;
                end
            end
            ST_DIV_RE: begin
                if (stat.div_done) begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = DIV_SEL_IM;
                    state_next    = ST_DIV_IM;
                end
            end
            ST_DIV_IM: begin
                if (stat.div_done) begin
                    ctl.div_start = 1'b1;
                    ctl.div_sel   = DIV_SEL_PW;
                    state_next    = ST_DIV_PW;
                end
            end
            ST_DIV_PW: begin
                if (stat.div_done) state_next = ST_MSQ;
            end
            ST_MSQ: begin
                ctl.mean_sq = 1'b1;
                state_next  = ST_VAR;
            end
            ST_VAR: begin
                ctl.var_calc = 1'b1;
                state_next   = ST_SQS;
            end
            ST_SQS: begin
                ctl.sqrt_start = 1'b1;
                state_next     = ST_SQRT;
            end
            ST_SQRT: begin
                if (stat.sqrt_done) state_next = ST_FIN;
            end
            ST_CLR_CMD: begin
                ctl.clr_step = 1'b1;
                if (stat.clr_last) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!stat.out_busy) begin
                    ctl.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.latch_in |=> state_reg == ST_ADDR)
        else $error("accepted request did not start address stage");

    a_clear_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.clr_step |-> !s_tready)
        else $error("request taken during clear sweep");

    a_load_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.res_load |=> s_tready)
        else $error("result load did not return to idle");

endmodule

// ===== sv/range_doppler_noise_statistics.sv =====
// top level of the range-doppler noise statistics accumulator
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid / s_tready  s_tuser command, s_tdata cell and sample
//  m_       out        m_tvalid / m_tready  m_tuser status, m_tdata means, variance, count
//  cfg_     in         cfg_valid/cfg_ready  cfg_index register, cfg_data value
//
// one request at a time; a query runs the real, imaginary and power divisions on the
// shared one-bit-per-cycle divider, then the square root, before its result is loaded
// reset and clear command run a zeroing sweep of MAX_DELAYS * MAX_DOPPLER cells
// (16384 at default), one cell per cycle, with s_tready low
// a new request is taken while a result waits in the output register; the
// following result waits for m_tready before it is loaded
module range_doppler_noise_statistics
    import rdns_pkg::*;
#(
    parameter int MAX_DELAYS  = 64,
    parameter int MAX_DOPPLER = 256,
    parameter int MAX_RECORDS = 4095
) (
    input  logic          aclk,
    input  logic          aresetn,
    // request stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [1:0]    s_tuser,   // command
    input  logic [63:0]   s_tdata,   // delay_bin, doppler_bin, sample_re, sample_im, pad
    // result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [2:0]    m_tuser,   // status
    output logic [151:0]  m_tdata,   // mean_re, mean_im, variance, std_dev, records_done, pad
    // register writes
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [47:0]   cfg_data
);

    dp_ctrl_t ctl;
    dp_stat_t stat;

    // register writes always taken, block is idle by contract
    assign cfg_ready = 1'b1;

    // sequencer: command decode, clear sweep, divider and root ordering
    rdns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctl      (ctl)
    );

    // cell memory and arithmetic
    rdns_datapath #(
        .MAX_DELAYS  (MAX_DELAYS),
        .MAX_DOPPLER (MAX_DOPPLER),
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .stat      (stat),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== dv/testbench.sv =====
// testbench for the range-doppler noise statistics block: directed and random requests
`timescale 1ns / 100ps

class cell_stats_board;
    // own copy of the per-cell sums, the record count and the registers
    logic [35:0] real_sum [16384];
    logic [35:0] imag_sum [16384];
    logic [59:0] power_sum [16384];
    logic [11:0] records;
    logic [6:0]  delays_cfg;
    logic [8:0]  fft_cfg;
    logic [47:0] limit_cfg;
    int          errors;

    typedef struct {
        rdns_pkg::status_code_t status;
        logic [31:0] mean_re;
        logic [31:0] mean_im;
        logic [47:0] variance;
        logic [23:0] std_dev;
        logic [11:0] records_done;
    } stats_result_t;

    stats_result_t awaited [$];

    function new();
        errors     = 0;
        delays_cfg = 7'd64;
        fft_cfg    = 9'd256;
        limit_cfg  = 48'd1;
        wipe();
    endfunction

    function void wipe();
        foreach (real_sum[k]) begin
            real_sum[k]  = '0;
            imag_sum[k]  = '0;
            power_sum[k] = '0;
        end
        records = '0;
    endfunction

    function void write_reg(rdns_pkg::cfg_index_t idx, logic [47:0] val);
        case (idx)
            rdns_pkg::CFG_DELAYS: delays_cfg = val[6:0];
            rdns_pkg::CFG_FFT:    fft_cfg = val[8:0];
            rdns_pkg::CFG_LIMIT:  limit_cfg = val;
            default: ;
        endcase
    endfunction

    function int pending();
        return awaited.size();
    endfunction

    function logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 23; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function longint mean_fix(logic [35:0] s);
        longint q;
        q = {{28{s[35]}}, s};
        q = (q * 256) / longint'(records);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    // work out the result of one accepted request and update the sums
    function void note_request(rdns_pkg::cmd_code_t cmd, logic [5:0] dly, logic [7:0] dop,
                               logic signed [23:0] re, logic signed [23:0] im);
        stats_result_t res;
        int nd;
        int nf;
        int addr;
        bit in_range;
        longint a;
        longint b;
        longint qr;
        longint qi;
        logic [63:0] ur;
        logic [63:0] ui;
        logic [63:0] sq;
        logic [63:0] pm;
        logic [63:0] v;
        nd = (delays_cfg > 64) ? 64 : delays_cfg;
        nf = (fft_cfg > 256) ? 256 : fft_cfg;
        in_range = (dly < nd) && (dop < nf);
        addr = in_range ? dop * nd + dly : 0;
        res = '{rdns_pkg::STS_OK, '0, '0, '0, '0, '0};
        case (cmd)
            rdns_pkg::CMD_CLEAR: wipe();
            rdns_pkg::CMD_ACCUM: begin
                if (!in_range) begin
                    res.status = rdns_pkg::STS_RANGE;
                end else begin
                    a = re;
                    b = im;
                    real_sum[addr] = real_sum[addr] + {{12{re[23]}}, re};
                    imag_sum[addr] = imag_sum[addr] + {{12{im[23]}}, im};
                    if (a < 0) a = -a;
                    if (b < 0) b = -b;
                    power_sum[addr] = power_sum[addr] + 60'(a * a + b * b);
                end
            end
            rdns_pkg::CMD_END: begin
                if (records >= 12'd4095) begin
                    records = 12'd4095;
                    res.status = rdns_pkg::STS_SATURATED;
                end else begin
                    records = records + 12'd1;
                end
            end
            default: begin
                if (!in_range) begin
                    res.status = rdns_pkg::STS_RANGE;
                end else if (records == 0) begin
                    res.status = rdns_pkg::STS_NO_REC;
                end else begin
                    qr = mean_fix(real_sum[addr]);
                    qi = mean_fix(imag_sum[addr]);
                    ur = (qr < 0) ? -qr : qr;
                    ui = (qi < 0) ? -qi : qi;
                    sq = (ur * ur + ui * ui) >> 16;
                    pm = {4'b0, power_sum[addr]} / {52'b0, records};
                    v = (pm > sq) ? pm - sq : '0;
                    if (v > 64'hFFFF_FFFF_FFFF) v = 64'hFFFF_FFFF_FFFF;
                    res.variance = v[47:0];
                    res.std_dev  = 24'(root_floor(v));
                    res.mean_re  = qr[31:0];
                    res.mean_im  = qi[31:0];
                    if (v[47:0] < limit_cfg) res.status = rdns_pkg::STS_LOW_VAR;
                end
            end
        endcase
        res.records_done = records;
        awaited.push_back(res);
    endfunction

    function bit field_ok(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
            return 0;
        end
        return 1;
    endfunction

    function void check_result(logic [2:0] status, logic [151:0] data);
        stats_result_t e;
        bit ok;
        if (awaited.size() == 0) begin
            $display("%0t: result with none expected, status %h data %h", $time, status, data);
            errors++;
            return;
        end
        e = awaited.pop_front();
        ok = field_ok("status", e.status, status);
        ok = field_ok("mean_re", e.mean_re, data[31:0]) && ok;
        ok = field_ok("mean_im", e.mean_im, data[63:32]) && ok;
        ok = field_ok("variance", e.variance, data[111:64]) && ok;
        ok = field_ok("std_dev", e.std_dev, data[135:112]) && ok;
        ok = field_ok("records_done", e.records_done, data[147:136]) && ok;
    endfunction
endclass

module testbench;
    import rdns_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [1:0]   s_tuser = CMD_CLEAR;   // command
    logic [63:0]  s_tdata = '0;          // delay_bin, doppler_bin, sample_re, sample_im, pad
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [2:0]   m_tuser;               // status
    logic [151:0] m_tdata;               // mean_re, mean_im, variance, std_dev, records_done, pad
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = CFG_DELAYS;
    logic [47:0]  cfg_data = '0;

    cell_stats_board board = new();

    // idle shaping: no_idle gives stretches at full rate, long_holds asks for a long stall
    bit no_idle = 0;
    int long_holds = 0;
    int stall_left = 0;

    range_doppler_noise_statistics uut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // a hard stop well past the slowest legal run
    initial begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, plus long holds on demand while requests keep coming
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
        if (long_holds > 0) begin
            long_holds--;
            stall_left = 500;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) stall_left = pick_gap();
        end
    end

    // offer one request and hold it until taken; valid stays up when no gap follows
    task automatic send_request(cmd_code_t cmd, logic [5:0] dly, logic [7:0] dop,
                                logic [23:0] re, logic [23:0] im);
        int gap;
        s_tuser  <= cmd;
        s_tdata  <= {2'b0, im, re, dop, dly};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_request(cmd, dly, dop, re, im);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // let every result come back before touching the registers
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [47:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        board.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(logic [47:0] dly_n, logic [47:0] fft_n, logic [47:0] lim);
        drain();
        write_reg(CFG_DELAYS, dly_n);
        write_reg(CFG_FFT, fft_n);
        write_reg(CFG_LIMIT, lim);
    endtask

    // sample value: full random, small, the extremes, or values just above 1000
    function automatic logic [23:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return 24'($urandom());
            1: return 24'($signed($urandom_range(0, 511)) - 256);
            2: return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
            default: return 24'($signed($urandom_range(0, 63)) + 1000);
        endcase
    endfunction

    task automatic random_phase(int count);
        int nd;
        int nf;
        int r;
        logic [5:0] dly;
        logic [7:0] dop;
        cmd_code_t cmd;
        nd = (board.delays_cfg > 64) ? 64 : board.delays_cfg;
        nf = (board.fft_cfg > 256) ? 256 : board.fft_cfg;
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 999);
            if (r < 4) cmd = CMD_CLEAR;
            else if (r < 580) cmd = CMD_ACCUM;
            else if (r < 720) cmd = CMD_END;
            else cmd = CMD_QUERY;
            // hot cells so that sums build up, some full-range and out-of-range bins
            r = $urandom_range(0, 99);
            if (nd == 0 || nf == 0 || r < 12) begin
                dly = 6'($urandom());
                dop = 8'($urandom());
            end else if (r < 60) begin
                dly = 6'($urandom_range(0, (nd < 3 ? nd : 3) - 1));
                dop = 8'($urandom_range(0, (nf < 3 ? nf : 3) - 1));
            end else begin
                dly = 6'($urandom_range(0, nd - 1));
                dop = 8'($urandom_range(0, nf - 1));
            end
            send_request(cmd, dly, dop, pick_sample(), pick_sample());
        end
        no_idle = 0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: no records, extreme samples at the corner cells, a mean that saturates
        send_request(CMD_QUERY, 0, 0, 0, 0);
        send_request(CMD_ACCUM, 0, 0, 24'h800000, 24'h7FFFFF);
        send_request(CMD_ACCUM, 63, 255, 24'h7FFFFF, 24'h800000);
        send_request(CMD_ACCUM, 63, 255, 24'h7FFFFF, 24'h7FFFFF);
        send_request(CMD_ACCUM, 0, 0, 24'h000001, 24'hFFFFFF);
        send_request(CMD_END, 0, 0, 0, 0);
        send_request(CMD_QUERY, 0, 0, 0, 0);
        send_request(CMD_QUERY, 63, 255, 0, 0);
        send_request(CMD_QUERY, 5, 7, 0, 0);
        send_request(CMD_CLEAR, 21, 33, 24'h123456, 24'h654321);
        send_request(CMD_QUERY, 63, 255, 0, 0);

        // small grid with bins just past the edge, a high limit to flag low variance
        configure(5, 3, 48'hFFFF_FFFF_FFFF);
        send_request(CMD_ACCUM, 5, 0, 24'h000100, 24'h000100);
        send_request(CMD_ACCUM, 4, 2, 24'h000100, 24'h000200);
        send_request(CMD_ACCUM, 0, 3, 24'h000100, 24'h000100);
        send_request(CMD_END, 63, 255, 0, 0);
        send_request(CMD_QUERY, 4, 2, 0, 0);
        send_request(CMD_QUERY, 0, 3, 0, 0);

        // zero sizes put every bin out of range, oversize values clamp to the maximum
        configure(0, 0, 0);
        send_request(CMD_ACCUM, 0, 0, 24'h000001, 24'h000001);
        send_request(CMD_QUERY, 0, 0, 0, 0);
        configure(127, 511, 1);
        send_request(CMD_ACCUM, 63, 255, 24'h7FFFFF, 24'h000000);
        send_request(CMD_QUERY, 63, 255, 0, 0);

        // end records with random bins, with a long result hold inside
        for (int k = 0; k < 6; k++) begin
            if (k == 2) long_holds++;
            send_request(CMD_END, 6'($urandom()), 8'($urandom()), 24'($urandom()),
                         24'($urandom()));
        end
        send_request(CMD_QUERY, 63, 255, 0, 0);

        // one cell driven with the most negative samples, then read back twice
        configure(64, 256, 1);
        send_request(CMD_CLEAR, 0, 0, 0, 0);
        for (int k = 0; k < 8; k++) begin
            send_request(CMD_ACCUM, 1, 1, 24'h800000, 24'h800000);
        end
        send_request(CMD_END, 0, 0, 0, 0);
        send_request(CMD_QUERY, 1, 1, 0, 0);
        send_request(CMD_END, 0, 0, 0, 0);
        send_request(CMD_QUERY, 1, 1, 0, 0);

        // random phases over several register settings
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: configure(64, 256, 1);
                1: configure(1, 1, 0);
                2: configure(127, 511, 48'hFFFF_FFFF_FFFF);
                3: configure(0, $urandom_range(1, 8), 1);
                4: configure($urandom_range(1, 8), 0, 1000);
                default: configure($urandom_range(1, 8), $urandom_range(1, 8),
                                   48'($urandom_range(0, 1) ? {$urandom(), $urandom()} >> 16
                                                            : $urandom_range(0, 100000)));
            endcase
            if (p == 5) long_holds++;
            random_phase(128);
        end

        drain();
        repeat (300) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/rdns_pkg.sv
sv/rdns_div.sv
sv/rdns_isqrt.sv
sv/rdns_datapath.sv
sv/rdns_ctrl.sv
sv/range_doppler_noise_statistics.sv
dv/testbench.sv
